// File: rtl/mbrc_pkg.sv
// Shared types and constants for the Modbus two-register reply checker.
// No dependencies; imported by every module of the block.
package mbrc_pkg;

  localparam logic [15:0] CRC_PRESET          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY            = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING   = 8'h03;
  localparam logic [7:0]  EXPECTED_BYTE_COUNT = 8'h04;
  localparam logic [7:0]  MIN_FRAME_BYTES     = 8'd9;

  localparam logic [7:0]  POS_FUNCTION = 8'd1;
  localparam logic [7:0]  POS_COUNT    = 8'd2;
  localparam logic [7:0]  POS_PAYLOAD0 = 8'd3;
  localparam logic [7:0]  POS_PAYLOAD3 = 8'd6;

  typedef struct packed {
    logic        ok;
    logic [15:0] reg_high;
    logic [15:0] reg_low;
  } mbrc_result_t;

endpackage

// File: rtl/modbus_two_register_reply_checker_unit.sv
// Top level of the Modbus RTU two-register reply checker: input and result registers.
// Depends on mbrc_pkg and mbrc_frame_check.
//
// Usage:
//   The slave channel (in_*) takes one reply byte per word, in wire order, with
//   in_tlast high on the final byte of the frame. Bytes that are not last give
//   no result. On the last byte the master channel (out_*) carries one word:
//   out_tuser is the ok flag, out_tdata carries both registers and their 32-bit
//   combination; all three are zero when the check fails.
//   A byte accepted into the input register is checked from there against the
//   frame state; the result of a last byte is registered into the word on out_tvalid.
//   Throughput: one byte per cycle while no last byte waits on the result word,
//   set by the single registered pass through the eight-step CRC and compare logic.
//   Reset (rst_n low, synchronous) clears the input and result valid flags and
//   returns the CRC to all ones and every counter and capture to zero. The same
//   frame state is cleared after each last byte, ready for the next frame.
//   When the receiver stalls, the result word holds; the input register keeps
//   taking non-last bytes, and a last byte waits until the result word drains.
module modbus_two_register_reply_checker_unit import mbrc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] reg_high, [31:16] reg_low, [63:32] combined_value
  output logic        out_tuser   // ok
);

  logic         s1_valid_r;
  logic [7:0]   s1_data_r;
  logic         s1_last_r;
  logic         go;
  mbrc_result_t res;

  logic         out_valid_r;
  logic         out_ok_r;
  logic [15:0]  out_high_r;
  logic [15:0]  out_low_r;

  assign go        = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  mbrc_frame_check #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (go),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && s1_last_r) begin
      out_ok_r   <= res.ok;
      out_high_r <= res.reg_high;
      out_low_r  <= res.reg_low;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {out_high_r, out_low_r, out_low_r, out_high_r};

endmodule

// File: rtl/mbrc_crc16.sv
// One-byte CRC-16 update, reflected polynomial, eight shift steps unrolled.
// Depends on mbrc_pkg for the polynomial.
module mbrc_crc16 import mbrc_pkg::*; (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// File: rtl/mbrc_frame_check.sv
// Frame state: running CRC, trailer delay, byte count, header and payload capture.
// Depends on mbrc_pkg and mbrc_crc16; builds the verdict on the last byte.
module mbrc_frame_check import mbrc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 255
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output mbrc_result_t result
);

  localparam logic [7:0] MAX_BYTES = 8'(MAX_FRAME_BYTES);

  logic [15:0] crc_r, crc_nxt, crc_step;
  logic [7:0]  seen_r, seen_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  pay_r [4];
  logic [7:0]  pay_nxt [4];
  logic [7:0]  td0_r, td0_nxt;
  logic [7:0]  td1_r, td1_nxt;
  logic        over_r, over_nxt;
  logic        ok;
  logic [1:0]  pay_idx;

  mbrc_crc16 u_crc (
    .crc_in  (crc_r),
    .data_in (td0_r),
    .crc_out (crc_step)
  );

  assign pay_idx = 2'(seen_r - POS_PAYLOAD0);

  always_comb begin
    crc_nxt   = (seen_r >= POS_COUNT) ? crc_step : crc_r;
    td0_nxt   = td1_r;
    td1_nxt   = data_byte;
    func_nxt  = (seen_r == POS_FUNCTION) ? data_byte : func_r;
    count_nxt = (seen_r == POS_COUNT) ? data_byte : count_r;
    for (int i = 0; i < 4; i++) begin
      pay_nxt[i] = pay_r[i];
    end
    if (seen_r >= POS_PAYLOAD0 && seen_r <= POS_PAYLOAD3) begin
      pay_nxt[pay_idx] = data_byte;
    end
    if (seen_r >= MAX_BYTES) begin
      over_nxt = 1'b1;
      seen_nxt = seen_r;
    end else begin
      over_nxt = over_r;
      seen_nxt = seen_r + 8'd1;
    end
    ok = !over_nxt && (seen_nxt >= MIN_FRAME_BYTES)
      && (func_nxt == FUNC_READ_HOLDING) && (count_nxt == EXPECTED_BYTE_COUNT)
      && (td0_nxt == crc_nxt[7:0]) && (td1_nxt == crc_nxt[15:8]);
    result.ok       = ok;
    result.reg_high = ok ? {pay_nxt[0], pay_nxt[1]} : 16'h0000;
    result.reg_low  = ok ? {pay_nxt[2], pay_nxt[3]} : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && last_byte)) begin
      crc_r   <= CRC_PRESET;
      seen_r  <= '0;
      func_r  <= '0;
      count_r <= '0;
      td0_r   <= '0;
      td1_r   <= '0;
      over_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        pay_r[i] <= '0;
      end
    end else if (advance) begin
      crc_r   <= crc_nxt;
      seen_r  <= seen_nxt;
      func_r  <= func_nxt;
      count_r <= count_nxt;
      td0_r   <= td0_nxt;
      td1_r   <= td1_nxt;
      over_r  <= over_nxt;
      for (int i = 0; i < 4; i++) begin
        pay_r[i] <= pay_nxt[i];
      end
    end
  end

endmodule
